/* rtl/core/trie_pkg.sv */
// trie_pkg: field widths and status codes of the trie insert / lookup engine
// used by the top level and its port checker, no dependencies
package trie_pkg;

    localparam int LETTER_W = 5;
    localparam int STATUS_W = 3;
    localparam int IDX_W    = 12;
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 16;

    localparam logic [STATUS_W-1:0] ST_NOPATH   = 3'd0;
    localparam logic [STATUS_W-1:0] ST_PREFIX   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_WORD     = 3'd2;
    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

endpackage

/* rtl/core/trie_ram.sv */
// trie_ram: simple dual-port synchronous ram, one write and one read port
// read data registered, held until the next read; no dependencies
module trie_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/trie_insert_lookup_engine.sv */
// trie_insert_lookup_engine: letter-serial prefix tree insert and lookup
// depends on trie_pkg and trie_ram (link store and per-node valid rows)
// missing link, lost word or new node: item registered at accept, valid in the next cycle
// existing link: item leaves the link state once the link read returns and output is free
// input stays closed while a link read is pending, as it feeds the next row read
// reset: synchronous, then a clearing pass over every row of the row ram, no input taken
module trie_insert_lookup_engine #(
    parameter int MAX_NODES = 4096,
    parameter int ALPHABET  = 26
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [trie_pkg::S_DATA_W-1:0]  s_axis_tdata,  // letter[4:0], zero pad
    input  logic                           s_axis_tuser,  // action
    input  logic                           s_axis_tlast,  // word_end
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [trie_pkg::M_DATA_W-1:0]  m_axis_tdata   // status[2:0], node_index[14:3], pad
);

    localparam int NODE_W     = $clog2(MAX_NODES);
    localparam int NF_W       = NODE_W + 1;
    localparam int LET_W      = $clog2(ALPHABET);
    localparam int LINK_DEPTH = MAX_NODES * ALPHABET;
    localparam int SLOT_W     = $clog2(LINK_DEPTH);
    localparam int LINK_W     = NODE_W + 1;

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_LINK  = 2'd2;
    localparam logic [1:0] S_ROW   = 2'd3;

    logic [1:0]                    r_state, n_state;
    logic [NODE_W-1:0]             r_clr_cnt, n_clr_cnt;
    logic [NODE_W-1:0]             r_cursor, n_cursor;
    logic [NF_W-1:0]               r_next_free, n_next_free;
    logic                          r_lost, n_lost;
    logic [ALPHABET-1:0]           r_row, n_row;
    logic [ALPHABET-1:0]           r_root_row, n_root_row;
    logic                          r_out_valid, n_out_valid;
    logic [SLOT_W-1:0]             r_slot, n_slot;
    logic                          r_action, n_action;
    logic                          r_last, n_last;
    logic [trie_pkg::STATUS_W-1:0] r_out_status, n_out_status;
    logic [trie_pkg::IDX_W-1:0]    r_out_node, n_out_node;

    logic                link_we, link_re;
    logic [SLOT_W-1:0]   link_waddr, link_raddr;
    logic [LINK_W-1:0]   link_wdata, link_rdata;
    logic                row_we, row_re;
    logic [NODE_W-1:0]   row_waddr, row_raddr;
    logic [ALPHABET-1:0] row_wdata, row_rdata;

    logic [trie_pkg::LETTER_W-1:0] w_letter;
    logic [LET_W-1:0]              w_let;
    logic                          w_in_range;
    logic [ALPHABET-1:0]           w_cur_row;
    logic [ALPHABET-1:0]           w_onehot;
    logic                          w_bit;
    logic [SLOT_W-1:0]             w_slot;
    logic                          w_full;
    logic                          w_go_link;
    logic                          w_out_free;
    logic                          w_acc;
    logic                          w_mark;
    logic [NODE_W-1:0]             w_child;

    trie_ram #(
        .DEPTH(LINK_DEPTH),
        .WIDTH(LINK_W)
    ) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (link_we),
        .i_waddr(link_waddr),
        .i_wdata(link_wdata),
        .i_re   (link_re),
        .i_raddr(link_raddr),
        .o_rdata(link_rdata)
    );

    trie_ram #(
        .DEPTH(MAX_NODES),
        .WIDTH(ALPHABET)
    ) u_row_ram (
        .i_clk  (i_clk),
        .i_we   (row_we),
        .i_waddr(row_waddr),
        .i_wdata(row_wdata),
        .i_re   (row_re),
        .i_raddr(row_raddr),
        .o_rdata(row_rdata)
    );

    assign w_letter   = s_axis_tdata[trie_pkg::LETTER_W-1:0];
    assign w_let      = LET_W'(w_letter);
    assign w_in_range = int'(w_letter) < ALPHABET;
    assign w_cur_row  = (r_state == S_ROW) ? row_rdata : r_row;
    assign w_onehot   = {{(ALPHABET-1){1'b0}}, 1'b1} << w_let;
    assign w_bit      = w_cur_row[w_let];
    assign w_slot     = SLOT_W'(r_cursor) * SLOT_W'(ALPHABET) + SLOT_W'(w_let);
    assign w_full     = r_next_free == NF_W'(MAX_NODES);
    assign w_go_link  = !r_lost && w_in_range && w_bit;
    assign w_mark     = link_rdata[NODE_W];
    assign w_child    = link_rdata[NODE_W-1:0];

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign s_axis_tready = ((r_state == S_IDLE) || (r_state == S_ROW)) && w_out_free;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    always_comb begin
        n_state      = r_state;
        n_clr_cnt    = r_clr_cnt;
        n_cursor     = r_cursor;
        n_next_free  = r_next_free;
        n_lost       = r_lost;
        n_row        = r_row;
        n_root_row   = r_root_row;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_slot       = r_slot;
        n_action     = r_action;
        n_last       = r_last;
        n_out_status = r_out_status;
        n_out_node   = r_out_node;
        link_we      = 1'b0;
        link_waddr   = w_slot;
        link_wdata   = {s_axis_tlast, r_next_free[NODE_W-1:0]};
        link_re      = 1'b0;
        link_raddr   = w_slot;
        row_we       = 1'b0;
        row_waddr    = r_cursor;
        row_wdata    = w_cur_row | w_onehot;
        row_re       = 1'b0;
        row_raddr    = w_child;

        unique case (r_state)
            S_CLEAR: begin
                row_we    = 1'b1;
                row_waddr = r_clr_cnt;
                row_wdata = '0;
                n_clr_cnt = r_clr_cnt + NODE_W'(1);
                if (r_clr_cnt == NODE_W'(MAX_NODES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE, S_ROW: begin
                n_row   = w_cur_row;
                n_state = S_IDLE;
                if (w_acc) begin
                    if (w_go_link) begin
                        link_re  = 1'b1;
                        n_slot   = w_slot;
                        n_action = s_axis_tuser;
                        n_last   = s_axis_tlast;
                        n_state  = S_LINK;
                    end else begin
                        n_out_valid  = 1'b1;
                        n_out_status = trie_pkg::ST_NOPATH;
                        n_out_node   = '0;
                        if (r_lost) begin
                            n_out_status = s_axis_tuser ? trie_pkg::ST_FULL
                                                        : trie_pkg::ST_NOPATH;
                        end else if (!w_in_range || !s_axis_tuser) begin
                            n_lost = 1'b1;
                        end else if (w_full) begin
                            n_lost       = 1'b1;
                            n_out_status = trie_pkg::ST_FULL;
                        end else begin
                            link_we      = 1'b1;
                            row_we       = 1'b1;
                            if (r_cursor == '0) begin
                                n_root_row = w_cur_row | w_onehot;
                            end
                            n_next_free  = r_next_free + NF_W'(1);
                            n_cursor     = r_next_free[NODE_W-1:0];
                            n_row        = '0;
                            n_out_status = trie_pkg::ST_INSERTED;
                            n_out_node   = trie_pkg::IDX_W'(r_next_free[NODE_W-1:0]);
                        end
                        if (s_axis_tlast) begin
                            n_cursor = '0;
                            n_lost   = 1'b0;
                            n_row    = n_root_row;
                        end
                    end
                end
            end
            S_LINK: begin
                if (w_out_free) begin
                    n_out_valid = 1'b1;
                    n_out_node  = trie_pkg::IDX_W'(w_child);
                    if (r_action) begin
                        n_out_status = trie_pkg::ST_INSERTED;
                        if (r_last && !w_mark) begin
                            link_we    = 1'b1;
                            link_waddr = r_slot;
                            link_wdata = {1'b1, w_child};
                        end
                    end else begin
                        n_out_status = w_mark ? trie_pkg::ST_WORD : trie_pkg::ST_PREFIX;
                    end
                    if (r_last) begin
                        n_cursor = '0;
                        n_row    = r_root_row;
                        n_state  = S_IDLE;
                    end else begin
                        n_cursor = w_child;
                        row_re   = 1'b1;
                        n_state  = S_ROW;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_cnt   <= '0;
            r_cursor    <= '0;
            r_next_free <= NF_W'(1);
            r_lost      <= 1'b0;
            r_row       <= '0;
            r_root_row  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_cnt   <= n_clr_cnt;
            r_cursor    <= n_cursor;
            r_next_free <= n_next_free;
            r_lost      <= n_lost;
            r_row       <= n_row;
            r_root_row  <= n_root_row;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot       <= n_slot;
        r_action     <= n_action;
        r_last       <= n_last;
        r_out_status <= n_out_status;
        r_out_node   <= n_out_node;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_node, r_out_status};

endmodule

/* rtl/core/trie_chk.sv */
// trie_chk: port checker for trie_insert_lookup_engine, bound to the top level
// depends on trie_pkg for status codes
module trie_chk (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [trie_pkg::M_DATA_W-1:0] m_axis_tdata
);

    logic [trie_pkg::STATUS_W-1:0] w_status;
    logic [trie_pkg::IDX_W-1:0]    w_node;

    assign w_status = m_axis_tdata[trie_pkg::STATUS_W-1:0];
    assign w_node   = m_axis_tdata[trie_pkg::STATUS_W +: trie_pkg::IDX_W];

    // clearing pass keeps input closed after reset
    a_clear_closed: assert property (@(posedge i_clk)
        !i_rst_n |=> !s_axis_tready)
        else $error("input ready straight after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled item changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> w_status == trie_pkg::ST_NOPATH || w_status == trie_pkg::ST_PREFIX
            || w_status == trie_pkg::ST_WORD || w_status == trie_pkg::ST_INSERTED
            || w_status == trie_pkg::ST_FULL)
        else $error("status code out of range");

    a_lost_node_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (w_status == trie_pkg::ST_NOPATH || w_status == trie_pkg::ST_FULL)
            |-> w_node == '0)
        else $error("node index set without a path");

endmodule

bind trie_insert_lookup_engine trie_chk u_trie_chk (.*);
